@@ hdl/lob_pkg.sv @@
// Shared types and constants for the limit order book matcher.
package lob_pkg;

	localparam int SIZE_W  = 16;
	localparam int PRICE_W = 17;
	localparam int SEQ_W   = 20;
	localparam int SUM_W   = 21;

	localparam logic [1:0] REQ_BUY    = 2'd0;
	localparam logic [1:0] REQ_SELL   = 2'd1;
	localparam logic [1:0] REQ_CANCEL = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_QUOTE = 1'b1;

	localparam logic [PRICE_W-1:0] EMPTY_ASK = 17'd99999;

	// Running result of one pass along the chain of slots
	typedef struct packed {
		logic               m_found;
		logic [PRICE_W-1:0] m_price;
		logic [SEQ_W-1:0]   m_seq;
		logic [SIZE_W-1:0]  m_size;
		logic               f_found;
		logic               b_found;
		logic [PRICE_W-1:0] b_price;
		logic [SUM_W-1:0]   b_sum;
		logic               a_found;
		logic [PRICE_W-1:0] a_price;
		logic [SUM_W-1:0]   a_sum;
	} scan_t;

	// Book update broadcast to every slot
	typedef struct packed {
		logic               fill;
		logic               rest;
		logic               cancel;
		logic               is_sell;
		logic [SIZE_W-1:0]  size;
		logic [PRICE_W-1:0] price;
		logic [SEQ_W-1:0]   seq;
	} wr_t;

endpackage

@@ hdl/lob_cell.sv @@
// One book slot: holds a resting order and folds it into the passing scan word.
module lob_cell #(
	parameter int DEPTH = 32,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     msell,
	input  lob_pkg::wr_t             wr,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	input  lob_pkg::scan_t           scan_in,
	input  logic [$clog2(DEPTH)-1:0] m_idx_in,
	input  logic [$clog2(DEPTH)-1:0] f_idx_in,
	output lob_pkg::scan_t           scan_out,
	output logic [$clog2(DEPTH)-1:0] m_idx_out,
	output logic [$clog2(DEPTH)-1:0] f_idx_out
);

	localparam int IW = $clog2(DEPTH);
	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic                          valid_q;
	logic                          sell_q;
	logic [lob_pkg::PRICE_W-1:0]   price_q;
	logic [lob_pkg::SIZE_W-1:0]    size_q;
	logic [lob_pkg::SEQ_W-1:0]     seq_q;
	lob_pkg::scan_t                nxt;
	logic [IW-1:0]                 m_idx_n;
	logic [IW-1:0]                 f_idx_n;
	lob_pkg::scan_t                rec_q;
	logic [IW-1:0]                 m_idx_q;
	logic [IW-1:0]                 f_idx_q;
	logic                          mine;

	assign mine = (wr_idx == MY_IDX);

	// Fold this slot into the scan word
	always_comb begin
		nxt     = scan_in;
		m_idx_n = m_idx_in;
		f_idx_n = f_idx_in;
		if (valid_q && sell_q == msell) begin
			if (!scan_in.m_found ||
			    (price_q == scan_in.m_price ? seq_q < scan_in.m_seq :
			     (msell ? price_q < scan_in.m_price : price_q > scan_in.m_price))) begin
				nxt.m_found = 1'b1;
				nxt.m_price = price_q;
				nxt.m_seq   = seq_q;
				nxt.m_size  = size_q;
				m_idx_n     = MY_IDX;
			end
		end
		if (!valid_q && !scan_in.f_found) begin
			nxt.f_found = 1'b1;
			f_idx_n     = MY_IDX;
		end
		if (valid_q && !sell_q) begin
			if (!scan_in.b_found || price_q > scan_in.b_price) begin
				nxt.b_found = 1'b1;
				nxt.b_price = price_q;
				nxt.b_sum   = lob_pkg::SUM_W'(size_q);
			end else if (price_q == scan_in.b_price) begin
				nxt.b_sum = scan_in.b_sum + lob_pkg::SUM_W'(size_q);
			end
		end
		if (valid_q && sell_q) begin
			if (!scan_in.a_found || price_q < scan_in.a_price) begin
				nxt.a_found = 1'b1;
				nxt.a_price = price_q;
				nxt.a_sum   = lob_pkg::SUM_W'(size_q);
			end else if (price_q == scan_in.a_price) begin
				nxt.a_sum = scan_in.a_sum + lob_pkg::SUM_W'(size_q);
			end
		end
	end

	// Hand the scan word to the next slot
	always_ff @(posedge clk) begin
		rec_q   <= nxt;
		m_idx_q <= m_idx_n;
		f_idx_q <= f_idx_n;
	end

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.rest && mine) begin
			valid_q <= 1'b1;
		end else if (wr.fill && mine && size_q == wr.size) begin
			valid_q <= 1'b0;
		end else if (wr.cancel && valid_q && seq_q == wr.seq) begin
			valid_q <= 1'b0;
		end
	end

	// Hold the resting order
	always_ff @(posedge clk) begin
		if (wr.rest && mine) begin
			sell_q  <= wr.is_sell;
			price_q <= wr.price;
			size_q  <= wr.size;
			seq_q   <= wr.seq;
		end else if (wr.fill && mine) begin
			size_q <= size_q - wr.size;
		end
	end

	assign scan_out  = rec_q;
	assign m_idx_out = m_idx_q;
	assign f_idx_out = f_idx_q;

endmodule

@@ hdl/limit_order_book_matcher.sv @@
// Each pass runs the scan word through all BOOK_DEPTH slots, then the evaluate state.
// A request takes one pass per trade, one more after resting, then the quote;
// one request is in work at a time.
// The next request is taken once the quote sits in the output register.
// Reset (arst_n low) empties the book and clears the id counter; no clearing pass.
// A waiting output word stalls the matcher only when the next word is ready.
module limit_order_book_matcher #(
	parameter int BOOK_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// order_size[15:0], order_price[32:16], cancel_ref[52:33], zero pad
	input  logic [55:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// trade_size[15:0], trade_price[32:16], bid_size[53:33], bid_price[70:54],
	// ask_size[91:71], ask_price[108:92], rest_dropped[109], zero pad
	output logic [111:0] m_tdata,
	// out_kind[0]
	output logic         m_tuser,
	output logic         m_tlast
);

	localparam int IW = $clog2(BOOK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_EVAL = 3'b100
	} state_t;

	state_t                          state_q;
	logic [IW-1:0]                   cnt_q;
	logic [lob_pkg::SEQ_W-1:0]       seq_q;
	logic                            sell_q;
	logic                            quote_q;
	logic                            dropped_q;
	logic [lob_pkg::SIZE_W-1:0]      size_q;
	logic [lob_pkg::PRICE_W-1:0]     price_q;
	logic                            out_valid_q;
	logic [111:0]                    out_data_q;
	logic                            out_kind_q;
	logic                            out_last_q;

	lob_pkg::scan_t                  scan [BOOK_DEPTH+1];
	logic [IW-1:0]                   midx [BOOK_DEPTH+1];
	logic [IW-1:0]                   fidx [BOOK_DEPTH+1];
	lob_pkg::wr_t                    wr;
	logic [IW-1:0]                   wr_idx;
	lob_pkg::scan_t                  res;
	logic                            accept;
	logic                            out_free;
	logic                            crosses;
	logic [lob_pkg::SIZE_W-1:0]      q;
	logic [lob_pkg::SEQ_W-1:0]       next_seq;
	logic                            is_order;
	logic [111:0]                    word_n;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign res      = scan[BOOK_DEPTH];
	assign next_seq = seq_q + 1'b1;
	assign is_order = (s_tuser == lob_pkg::REQ_BUY) || (s_tuser == lob_pkg::REQ_SELL);
	assign crosses  = res.m_found &&
	                  (sell_q ? res.m_price >= price_q : res.m_price <= price_q);
	assign q        = (size_q < res.m_size) ? size_q : res.m_size;

	// Seed the chain with an empty scan word
	assign scan[0] = '0;
	assign midx[0] = '0;
	assign fidx[0] = '0;

	// Build the row of slots
	for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
		lob_cell #(.DEPTH(BOOK_DEPTH), .INDEX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.msell    (!sell_q),
			.wr       (wr),
			.wr_idx   (wr_idx),
			.scan_in  (scan[i]),
			.m_idx_in (midx[i]),
			.f_idx_in (fidx[i]),
			.scan_out (scan[i+1]),
			.m_idx_out(midx[i+1]),
			.f_idx_out(fidx[i+1])
		);
	end

	// Drive book updates: cancel at accept, fill or rest at evaluate
	always_comb begin
		wr       = '0;
		wr_idx   = midx[BOOK_DEPTH];
		if (accept && s_tuser == lob_pkg::REQ_CANCEL) begin
			wr.cancel = 1'b1;
			wr.seq    = s_tdata[52:33];
		end else if (state_q == S_EVAL && !quote_q) begin
			if (crosses) begin
				wr.fill = out_free;
				wr.size = q;
			end else if (res.f_found) begin
				wr.rest    = 1'b1;
				wr.is_sell = sell_q;
				wr.price   = price_q;
				wr.size    = size_q;
				wr.seq     = seq_q;
				wr_idx     = fidx[BOOK_DEPTH];
			end
		end
	end

	// Sequence the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			seq_q     <= '0;
			quote_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						seq_q     <= next_seq;
						quote_q   <= !(is_order && s_tdata[15:0] != '0);
						dropped_q <= 1'b0;
						cnt_q     <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IW'(BOOK_DEPTH - 1)) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					cnt_q <= '0;
					if (quote_q) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else if (crosses) begin
						if (out_free) begin
							quote_q <= (size_q == q);
							state_q <= S_SCAN;
						end
					end else begin
						dropped_q <= !res.f_found;
						quote_q   <= 1'b1;
						state_q   <= S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch the order and drain its size on each fill
	always_ff @(posedge clk) begin
		if (accept) begin
			sell_q  <= (s_tuser == lob_pkg::REQ_SELL);
			size_q  <= s_tdata[15:0];
			price_q <= s_tdata[32:16];
		end else if (state_q == S_EVAL && !quote_q && crosses && out_free) begin
			size_q <= size_q - q;
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EVAL && out_free && (quote_q || crosses)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Pack the next output word: quote or trade
	always_comb begin
		word_n = '0;
		if (quote_q) begin
			word_n[53:33]  = res.b_found ? res.b_sum : '0;
			word_n[70:54]  = res.b_found ? res.b_price : '0;
			word_n[91:71]  = res.a_found ? res.a_sum : '0;
			word_n[108:92] = res.a_found ? res.a_price : lob_pkg::EMPTY_ASK;
			word_n[109]    = dropped_q;
		end else begin
			word_n[15:0]   = q;
			word_n[32:16]  = res.m_price;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL && out_free && (quote_q || crosses)) begin
			out_data_q <= word_n;
			out_kind_q <= quote_q ? lob_pkg::KIND_QUOTE : lob_pkg::KIND_TRADE;
			out_last_q <= quote_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_start: assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q == S_SCAN)
		else $error("accepted request did not start a scan");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == lob_pkg::KIND_QUOTE)))
		else $error("last flag does not mark the quote word");
	a_trade: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == lob_pkg::KIND_TRADE) |-> m_tdata[15:0] != '0)
		else $error("trade word with zero size");
`endif

endmodule
